// ----- rtl/stream_group_packetizer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stream group packetizer
// Clocked concurrent assertions. Defining NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef STREAM_GROUP_PACKETIZER_MACROS_SVH
`define STREAM_GROUP_PACKETIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Assertion that is checked only outside reset
`define SGP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sgp assertion failed");

// Assertion that is checked at every edge, reset included
`define SGP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sgp assertion failed");

`else

`define SGP_ASSERT(label, clk, rst_n, prop)
`define SGP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- rtl/sgp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgp_pkg
// Types and constants shared by the stream group packetizer modules.
// ----------------------------------------------------------------------------
package sgp_pkg;

    // Field widths
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CFG_W  = 7;
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned OP_W   = 2;

    // Defaults for top-level parameters
    localparam int unsigned BUFFER_DEPTH_DEF = 64;
    localparam int unsigned QUEUE_DEPTH_DEF  = 4;

    // Group size after reset
    localparam logic [CFG_W-1:0] GROUP_SIZE_RST = CFG_W'(1);

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_DATA  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_FLUSH = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_CLEAR = CMD_W'(2);

    // Operations handed from front to back
    typedef enum logic [OP_W-1:0] {
        OP_STORE,
        OP_EMIT_STORE,
        OP_FLUSH
    } t_op;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EMIT,
        BK_WRITE
    } t_back_state;

    // Input request payload
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] data_word;
    } t_sgp_in;

    // Output request payload
    typedef struct packed {
        logic [DATA_W-1:0] out_word;
        logic              last;
        logic              empty_res;
    } t_sgp_out;

endpackage

// ----- rtl/stream_group_packetizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_group_packetizer
// Gathers data words into groups of a configured size and emits them lazily.
// ----------------------------------------------------------------------------
// Data and flush requests are taken one per cycle into a queue of QUEUE_DEPTH
// operations; a clear request is settled in the front end and never queued.
// Input stalls only while that queue is full. A data request that only stores
// its word is written to the group buffer as its operation is popped. Emitting
// a stored group of n words first pops and loads the operation, then reads
// the n words, one buffer read per cycle on the single read port of the group
// buffer, and then stores the word that triggered it when a data request
// caused the emission; an empty flush yields one empty result. A stalled
// result register holds the buffer reads back. Results pass through a read
// register and the output register after their buffer read is issued. There
// is no clearing pass after reset.
module stream_group_packetizer
    import sgp_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_sgp_in          i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_sgp_out         o_out,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int unsigned CNT_W   = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned ENTRY_W = OP_W + CNT_W + DATA_W;

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic [ENTRY_W-1:0] q_wdata;
    logic [ENTRY_W-1:0] q_rdata;

    sgp_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    sgp_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sgp_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// ----- rtl/sgp_front.sv -----
`timescale 1ns / 1ps
`include "stream_group_packetizer_macros.svh"
// ----------------------------------------------------------------------------
// sgp_front
// Accepts input requests, tracks the buffer fill and turns each data or flush
// request into an operation for the back end.
// ----------------------------------------------------------------------------
module sgp_front
    import sgp_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_in_valid,
    output logic                                              o_in_stall,
    input  t_sgp_in                                           i_in,
    input  logic                                              i_cfg_we,
    input  logic [CFG_W-1:0]                                  i_cfg_wdata,
    input  logic                                              i_q_full,
    output logic                                              o_q_push,
    output logic [OP_W+$clog2(BUFFER_DEPTH+1)+DATA_W-1:0]     o_q_data
);

    localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0] r_group_size;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CMP_W-1:0] gs_ext;
    logic [CMP_W-1:0] eff_size;
    logic             full;
    logic             accept;
    t_op              op;

    // Group size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GROUP_SIZE_RST;
        end else if (i_cfg_we) begin
            r_group_size <= i_cfg_wdata;
        end
    end

    // Effective group size: zero acts as one, saturate at the buffer depth
    always_comb begin
        gs_ext = CMP_W'(r_group_size);
        if (gs_ext == '0) begin
            eff_size = CMP_W'(1);
        end else if (gs_ext > CMP_W'(BUFFER_DEPTH)) begin
            eff_size = CMP_W'(BUFFER_DEPTH);
        end else begin
            eff_size = gs_ext;
        end
    end

    assign full       = CMP_W'(r_count) >= eff_size;
    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // Classify the request and update the fill count
    always_comb begin
        o_q_push = 1'b0;
        op       = OP_STORE;
        n_count  = r_count;
        if (accept) begin
            unique case (i_in.command)
                CMD_DATA: begin
                    o_q_push = 1'b1;
                    if (full) begin
                        op      = OP_EMIT_STORE;
                        n_count = CNT_W'(1);
                    end else begin
                        op      = OP_STORE;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_FLUSH: begin
                    o_q_push = 1'b1;
                    op       = OP_FLUSH;
                    n_count  = '0;
                end
                CMD_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    // undefined command: dropped
                    n_count = r_count;
                end
            endcase
        end
    end

    // Entry: operation, fill count before this request, data word
    assign o_q_data = {op, r_count, i_in.data_word};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    `SGP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(BUFFER_DEPTH))

endmodule

// ----- rtl/sgp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgp_queue
// Small FIFO of operations between the front and back ends.
// ----------------------------------------------------------------------------
module sgp_queue
    import sgp_pkg::*;
#(
    parameter int unsigned WIDTH = OP_W + DATA_W,
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/sgp_back.sv -----
`timescale 1ns / 1ps
`include "stream_group_packetizer_macros.svh"
// ----------------------------------------------------------------------------
// sgp_back
// Holds the group buffer, carries out queued operations and drives the
// output register.
// ----------------------------------------------------------------------------
module sgp_back
    import sgp_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_q_empty,
    input  logic [OP_W+$clog2(BUFFER_DEPTH+1)+DATA_W-1:0]     i_q_data,
    output logic                                              o_q_pop,
    output logic                                              o_out_valid,
    input  logic                                              i_out_stall,
    output t_sgp_out                                          o_out
);

    localparam int unsigned CNT_W   = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned ADDR_W  = $clog2(BUFFER_DEPTH);
    localparam int unsigned ENTRY_W = OP_W + CNT_W + DATA_W;

    // Queue entry fields
    t_op               q_op;
    logic [CNT_W-1:0]  q_cnt;
    logic [DATA_W-1:0] q_word;

    assign q_op   = t_op'(i_q_data[ENTRY_W-1 -: OP_W]);
    assign q_cnt  = i_q_data[DATA_W +: CNT_W];
    assign q_word = i_q_data[DATA_W-1:0];

    t_back_state       r_state;
    t_back_state       n_state;
    logic [ADDR_W-1:0] r_k;
    logic [CNT_W-1:0]  r_n;
    logic              r_store;
    logic [DATA_W-1:0] r_word;

    logic [DATA_W-1:0] r_mem [BUFFER_DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_valid;
    logic              r_rd_last;
    logic              r_rd_empty;
    logic              r_out_valid;
    t_sgp_out          r_out;

    logic              out_ready;
    logic              rd_adv;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_last;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              inject_empty;
    logic              load;
    logic              emit_last;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign rd_adv    = !r_rd_valid || out_ready;
    assign emit_last = (CNT_W'(r_k) + CNT_W'(1)) == r_n;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    unique case (q_op)
                        OP_EMIT_STORE: n_state = BK_EMIT;
                        OP_FLUSH:      n_state = (q_cnt != '0) ? BK_EMIT : BK_IDLE;
                        default:       n_state = BK_IDLE;
                    endcase
                end
            end
            BK_EMIT: begin
                if (rd_adv && emit_last) begin
                    n_state = r_store ? BK_WRITE : BK_IDLE;
                end
            end
            BK_WRITE: n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_q_pop      = 1'b0;
        load         = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_k;
        rd_last      = emit_last;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = r_word;
        inject_empty = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    unique case (q_op)
                        OP_STORE: begin
                            o_q_pop = 1'b1;
                            wr_en   = 1'b1;
                            wr_addr = q_cnt[ADDR_W-1:0];
                            wr_data = q_word;
                        end
                        OP_EMIT_STORE: begin
                            o_q_pop = 1'b1;
                            load    = 1'b1;
                        end
                        OP_FLUSH: begin
                            if (q_cnt != '0) begin
                                o_q_pop = 1'b1;
                                load    = 1'b1;
                            end else if (rd_adv) begin
                                // flush of an empty buffer: one empty result
                                o_q_pop      = 1'b1;
                                inject_empty = 1'b1;
                            end
                        end
                        default: o_q_pop = 1'b0;
                    endcase
                end
            end
            BK_EMIT: begin
                rd_en = rd_adv;
            end
            BK_WRITE: begin
                // new word goes to the head of the emptied buffer
                wr_en = 1'b1;
            end
            default: o_q_pop = 1'b0;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_k     <= '0;
            r_n     <= q_cnt;
            r_store <= q_op == OP_EMIT_STORE;
            r_word  <= q_word;
        end else if (rd_en) begin
            r_k <= r_k + ADDR_W'(1);
        end
    end

    // Group buffer, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Read stage flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (rd_adv) begin
            r_rd_valid <= rd_en || inject_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_adv) begin
            r_rd_last  <= rd_en ? rd_last : 1'b1;
            r_rd_empty <= inject_empty;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out.out_word  <= r_rd_empty ? '0 : r_rd_data;
            r_out.last      <= r_rd_last;
            r_out.empty_res <= r_rd_empty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `SGP_ASSERT(a_no_rw_overlap, i_clk, i_rst_n, !(wr_en && rd_en))
    `SGP_ASSERT(a_pop_nonempty, i_clk, i_rst_n, o_q_pop |-> !i_q_empty)
    `SGP_ASSERT(a_emit_in_range, i_clk, i_rst_n, (r_state == BK_EMIT) |-> (CNT_W'(r_k) < r_n))
    `SGP_ASSERT(a_empty_is_last, i_clk, i_rst_n, (r_rd_valid && r_rd_empty) |-> r_rd_last)

endmodule
